// ===== design/assert_macros.svh =====
// Assertion helper macros shared by the ray and wall intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/rsi_pkg.sv =====
// Shared types and constants of the ray and wall segment intersection block.
package rsi_pkg;

    // Field and register widths fixed by the interface.
    localparam int FIELD_W     = 16;
    localparam int OUT_W       = 24;
    localparam int CFG_INDEX_W = 2;

    // Limits of the signed 24-bit result coordinates.
    localparam int OUT_MAX     = 8388607;
    localparam int OUT_MIN_MAG = 8388608;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RAY_ORIGIN_X  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RAY_ORIGIN_Y  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAY_THROUGH_X = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RAY_THROUGH_Y = 2'd3;

    // Configuration reset values.
    localparam logic [FIELD_W-1:0] RAY_ORIGIN_X_RST  = 16'd0;
    localparam logic [FIELD_W-1:0] RAY_ORIGIN_Y_RST  = 16'd0;
    localparam logic [FIELD_W-1:0] RAY_THROUGH_X_RST = 16'd100;
    localparam logic [FIELD_W-1:0] RAY_THROUGH_Y_RST = 16'd20;

    // One wall segment per input transaction.
    typedef struct packed {
        logic signed [FIELD_W-1:0] wall_start_x;
        logic signed [FIELD_W-1:0] wall_start_y;
        logic signed [FIELD_W-1:0] wall_end_x;
        logic signed [FIELD_W-1:0] wall_end_y;
    } wall_t;

    // One intersection result per output transaction.
    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] hit_x;
        logic signed [OUT_W-1:0] hit_y;
    } result_t;

    // Control bits that travel alongside a quotient through the divider.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg;
    } rsi_tag_t;

endpackage

// ===== design/rsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`include "assert_macros.svh"

module rsi_divider #(
    parameter int DEN_W = 33,
    parameter int QB    = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  rsi_pkg::rsi_tag_t  in_tag,
    input  logic [DEN_W-1:0]   in_rem,
    input  logic [QB-1:0]      in_low,
    input  logic [DEN_W-1:0]   in_dvs,
    output rsi_pkg::rsi_tag_t  out_tag,
    output logic [QB-1:0]      out_quo
);

    // Per-stage partial remainder, dividend/quotient shift word, divisor and tag.
    logic [DEN_W-1:0]  rem_reg  [QB];
    logic [QB-1:0]     low_reg  [QB];
    logic [DEN_W-1:0]  dvs_reg  [QB];
    rsi_pkg::rsi_tag_t tag_reg  [QB];
    logic [DEN_W-1:0]  rem_next [QB];
    logic [QB-1:0]     low_next [QB];

    for (genvar i = 0; i < QB; i++) begin : g_step
        logic [DEN_W-1:0]  rem_src;
        logic [QB-1:0]     low_src;
        logic [DEN_W-1:0]  dvs_src;
        rsi_pkg::rsi_tag_t tag_src;
        logic [DEN_W:0]    trial;
        logic              take;

        // Each stage reads the stage before it; the first reads the inputs.
        if (i == 0) begin : g_first
            assign rem_src = in_rem;
            assign low_src = in_low;
            assign dvs_src = in_dvs;
            assign tag_src = in_tag;
        end else begin : g_rest
            assign rem_src = rem_reg[i-1];
            assign low_src = low_reg[i-1];
            assign dvs_src = dvs_reg[i-1];
            assign tag_src = tag_reg[i-1];
        end

        // Shift in the next dividend bit and subtract the divisor when it fits.
        assign trial       = {rem_src, low_src[QB-1]};
        assign take        = trial >= {1'b0, dvs_src};
        assign rem_next[i] = take ? DEN_W'(trial - {1'b0, dvs_src}) : trial[DEN_W-1:0];
        assign low_next[i] = {low_src[QB-2:0], take};

        // Tag carries the valid bit, so it is cleared by reset.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i] <= '0;
            end else if (en) begin
                tag_reg[i] <= tag_src;
            end
        end

        // Arithmetic payload advances with the pipeline.
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                dvs_reg[i] <= dvs_src;
            end
        end
    end

    assign out_tag = tag_reg[QB-1];
    assign out_quo = low_reg[QB-1];

    // A valid hit always leaves a remainder below the divisor.
    `ASSERT_IMPLIES(a_rem_below_dvs, aclk, aresetn,
        tag_reg[QB-1].valid && tag_reg[QB-1].hit, rem_reg[QB-1] < dvs_reg[QB-1])

endmodule

// ===== design/ray_segment_intersection.sv =====
// Top level of the ray against wall segment intersection pipeline.
//
// Usage: the ray is set through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) as an origin point and a second point
// that fixes its direction. Write it only while no wall is in flight.
// Each input transaction on s_valid/s_ready/s_data carries one wall
// segment; each output transaction on m_valid/m_ready/m_data returns one
// result: hit, and the crossing point in signed fixed point with
// FRAC_BITS fraction bits (zero when there is no hit).
// Throughput is one wall per cycle while the output is not stalled. From
// acceptance to m_valid a wall passes eight stages of determinant and
// interpolation arithmetic, one restoring divider stage per quotient bit,
// and the output register.
// Reset clears all pipeline valid bits and loads the ray registers with
// origin (0,0) and second point (100,20); s_ready and cfg_ready stay low
// while reset is asserted. When m_valid is high and m_ready is low, the whole
// pipeline freezes and s_ready drops; nothing is lost.
`include "assert_macros.svh"

module ray_segment_intersection #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rsi_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rsi_pkg::FIELD_W-1:0]           cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rsi_pkg::wall_t                        s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rsi_pkg::result_t                      m_data
);

    // Widths derived from the effective coordinate width.
    localparam int EFF   = (COORD_WIDTH < rsi_pkg::FIELD_W) ? COORD_WIDTH : rsi_pkg::FIELD_W;
    localparam int DW1   = EFF + 1;
    localparam int PW    = 2 * EFF + 2;
    localparam int DEN_W = 2 * EFF + 1;
    localparam int PRW   = EFF + DEN_W + 1;
    localparam int NW    = PRW + 1;
    localparam int MW    = EFF + DEN_W;
    localparam int QB    = EFF + FRAC_BITS;
    localparam int DVW   = MW + FRAC_BITS;
    localparam int QE    = ((QB > rsi_pkg::OUT_W) ? QB : rsi_pkg::OUT_W) + 1;
    localparam int OW    = rsi_pkg::OUT_W;

    localparam logic [QE-1:0] POS_LIM = QE'(rsi_pkg::OUT_MAX);
    localparam logic [QE-1:0] NEG_LIM = QE'(rsi_pkg::OUT_MIN_MAG);
    localparam logic [OW-1:0] SAT_MAX = OW'(rsi_pkg::OUT_MAX);
    localparam logic [OW-1:0] SAT_MIN = OW'(rsi_pkg::OUT_MIN_MAG);

    // Wall endpoints carried down the pipeline.
    typedef struct packed {
        logic signed [EFF-1:0] x1;
        logic signed [EFF-1:0] y1;
        logic signed [EFF-1:0] x2;
        logic signed [EFF-1:0] y2;
    } pts_t;

    // Configuration registers.
    logic [rsi_pkg::FIELD_W-1:0] ox_reg, oy_reg, tx_reg, ty_reg;

    // Pipeline control.
    logic       adv;
    logic [7:0] vld_reg;
    logic [7:0] vld_next;
    logic       hit4_reg, hit5_reg, hit6_reg, hit7_reg, hit8_reg;
    logic       hit4_next;

    // Stage 1: differences.
    pts_t                  pts1_reg, pts1_next;
    logic signed [DW1-1:0] a1_reg, b1_reg, c1_reg, d1_reg, e1_reg, f1_reg;
    logic signed [DW1-1:0] a1_next, b1_next, c1_next, d1_next, e1_next, f1_next;
    // Stage 2: cross products.
    pts_t                  pts2_reg;
    logic signed [PW-1:0]  ae2_reg, bf2_reg, ce2_reg, df2_reg, ad2_reg, bc2_reg;
    // Stage 3: determinants.
    pts_t                  pts3_reg;
    logic signed [PW-1:0]  den3_reg, tn3_reg, un3_reg;
    // Stage 4: sign-normalized magnitudes.
    pts_t                  pts4_reg;
    logic [DEN_W-1:0]      dn4_reg, tn4_reg, dn4_next, tn4_next;
    // Stage 5: interpolation weight.
    pts_t                  pts5_reg;
    logic [DEN_W-1:0]      dn5_reg, tn5_reg, w5_reg;
    // Stage 6: weighted endpoints.
    logic [DEN_W-1:0]      dn6_reg;
    logic signed [PRW-1:0] px1_6_reg, px2_6_reg, py1_6_reg, py2_6_reg;
    // Stage 7: numerators.
    logic [DEN_W-1:0]      dn7_reg;
    logic signed [NW-1:0]  nx7_reg, ny7_reg;
    // Stage 8: numerator magnitudes and signs.
    logic [DEN_W-1:0]      dn8_reg;
    logic [MW-1:0]         mx8_reg, my8_reg;
    logic                  negx8_reg, negy8_reg;

    // Divider interface.
    logic [DVW-1:0]        dvd_x, dvd_y;
    rsi_pkg::rsi_tag_t     tag_x_in, tag_y_in, tag_x_out, tag_y_out;
    logic [QB-1:0]         quo_x, quo_y;

    // Output register.
    logic                  m_valid_reg;
    rsi_pkg::result_t      m_data_reg, m_data_next;

    // The pipeline moves as a whole whenever the output register can take a result.
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = aresetn && adv;
    assign cfg_ready = aresetn;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg <= rsi_pkg::RAY_ORIGIN_X_RST;
            oy_reg <= rsi_pkg::RAY_ORIGIN_Y_RST;
            tx_reg <= rsi_pkg::RAY_THROUGH_X_RST;
            ty_reg <= rsi_pkg::RAY_THROUGH_Y_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rsi_pkg::REG_RAY_ORIGIN_X:  ox_reg <= cfg_data;
                rsi_pkg::REG_RAY_ORIGIN_Y:  oy_reg <= cfg_data;
                rsi_pkg::REG_RAY_THROUGH_X: tx_reg <= cfg_data;
                rsi_pkg::REG_RAY_THROUGH_Y: ty_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage 1 inputs: sign-extended coordinates and their differences.
    always_comb begin
        pts1_next.x1 = $signed(s_data.wall_start_x[EFF-1:0]);
        pts1_next.y1 = $signed(s_data.wall_start_y[EFF-1:0]);
        pts1_next.x2 = $signed(s_data.wall_end_x[EFF-1:0]);
        pts1_next.y2 = $signed(s_data.wall_end_y[EFF-1:0]);
        a1_next = DW1'(pts1_next.x1) - DW1'(pts1_next.x2);
        b1_next = DW1'(pts1_next.y1) - DW1'(pts1_next.y2);
        c1_next = DW1'(pts1_next.x1) - DW1'($signed(ox_reg[EFF-1:0]));
        d1_next = DW1'(pts1_next.y1) - DW1'($signed(oy_reg[EFF-1:0]));
        e1_next = DW1'($signed(oy_reg[EFF-1:0])) - DW1'($signed(ty_reg[EFF-1:0]));
        f1_next = DW1'($signed(ox_reg[EFF-1:0])) - DW1'($signed(tx_reg[EFF-1:0]));
    end

    // Stage 4 inputs: hit test by the sign of the denominator, and magnitudes.
    always_comb begin
        hit4_next = 1'b0;
        if (!den3_reg[PW-1] && (den3_reg != '0)) begin
            hit4_next = (tn3_reg > 0) && (tn3_reg < den3_reg) && (un3_reg > 0);
        end else if (den3_reg[PW-1]) begin
            hit4_next = (tn3_reg < 0) && (tn3_reg > den3_reg) && (un3_reg < 0);
        end
        dn4_next = den3_reg[PW-1] ? DEN_W'(-den3_reg) : DEN_W'(den3_reg);
        tn4_next = den3_reg[PW-1] ? DEN_W'(-tn3_reg) : DEN_W'(tn3_reg);
    end

    // Valid flags of the arithmetic stages.
    assign vld_next = {vld_reg[6:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Arithmetic stages 1 to 8.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pts1_reg  <= pts1_next;
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            c1_reg    <= c1_next;
            d1_reg    <= d1_next;
            e1_reg    <= e1_next;
            f1_reg    <= f1_next;

            pts2_reg  <= pts1_reg;
            ae2_reg   <= PW'(a1_reg) * PW'(e1_reg);
            bf2_reg   <= PW'(b1_reg) * PW'(f1_reg);
            ce2_reg   <= PW'(c1_reg) * PW'(e1_reg);
            df2_reg   <= PW'(d1_reg) * PW'(f1_reg);
            ad2_reg   <= PW'(a1_reg) * PW'(d1_reg);
            bc2_reg   <= PW'(b1_reg) * PW'(c1_reg);

            pts3_reg  <= pts2_reg;
            den3_reg  <= ae2_reg - bf2_reg;
            tn3_reg   <= ce2_reg - df2_reg;
            un3_reg   <= bc2_reg - ad2_reg;

            pts4_reg  <= pts3_reg;
            hit4_reg  <= hit4_next;
            dn4_reg   <= dn4_next;
            tn4_reg   <= tn4_next;

            pts5_reg  <= pts4_reg;
            hit5_reg  <= hit4_reg;
            dn5_reg   <= dn4_reg;
            tn5_reg   <= tn4_reg;
            w5_reg    <= dn4_reg - tn4_reg;

            hit6_reg  <= hit5_reg;
            dn6_reg   <= dn5_reg;
            px1_6_reg <= PRW'(pts5_reg.x1) * $signed(PRW'(w5_reg));
            px2_6_reg <= PRW'(pts5_reg.x2) * $signed(PRW'(tn5_reg));
            py1_6_reg <= PRW'(pts5_reg.y1) * $signed(PRW'(w5_reg));
            py2_6_reg <= PRW'(pts5_reg.y2) * $signed(PRW'(tn5_reg));

            hit7_reg  <= hit6_reg;
            dn7_reg   <= dn6_reg;
            nx7_reg   <= NW'(px1_6_reg) + NW'(px2_6_reg);
            ny7_reg   <= NW'(py1_6_reg) + NW'(py2_6_reg);

            hit8_reg  <= hit7_reg;
            dn8_reg   <= dn7_reg;
            negx8_reg <= nx7_reg[NW-1];
            negy8_reg <= ny7_reg[NW-1];
            mx8_reg   <= nx7_reg[NW-1] ? MW'(-nx7_reg) : MW'(nx7_reg);
            my8_reg   <= ny7_reg[NW-1] ? MW'(-ny7_reg) : MW'(ny7_reg);
        end
    end

    // Scaled dividends: the high part seeds the remainder, the low part shifts in.
    assign dvd_x    = DVW'(mx8_reg) << FRAC_BITS;
    assign dvd_y    = DVW'(my8_reg) << FRAC_BITS;
    assign tag_x_in = '{valid: vld_reg[7], hit: hit8_reg, neg: negx8_reg};
    assign tag_y_in = '{valid: vld_reg[7], hit: hit8_reg, neg: negy8_reg};

    rsi_divider #(
        .DEN_W (DEN_W),
        .QB    (QB)
    ) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_tag  (tag_x_in),
        .in_rem  (dvd_x[DVW-1:QB]),
        .in_low  (dvd_x[QB-1:0]),
        .in_dvs  (dn8_reg),
        .out_tag (tag_x_out),
        .out_quo (quo_x)
    );

    rsi_divider #(
        .DEN_W (DEN_W),
        .QB    (QB)
    ) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_tag  (tag_y_in),
        .in_rem  (dvd_y[DVW-1:QB]),
        .in_low  (dvd_y[QB-1:0]),
        .in_dvs  (dn8_reg),
        .out_tag (tag_y_out),
        .out_quo (quo_y)
    );

    // Apply the sign and saturate a quotient magnitude to the output range; zero on a miss.
    function automatic logic [OW-1:0] sat_coord(input logic [QB-1:0] q, input logic neg,
                                                input logic hit);
        logic [QE-1:0] qe;
        logic [OW-1:0] res;
        qe = QE'(q);
        if (!hit) begin
            res = '0;
        end else if (neg) begin
            res = (qe > NEG_LIM) ? SAT_MIN : OW'(-qe);
        end else begin
            res = (qe > POS_LIM) ? SAT_MAX : qe[OW-1:0];
        end
        return res;
    endfunction

    // Output stage result.
    always_comb begin
        m_data_next.hit   = tag_x_out.hit;
        m_data_next.hit_x = $signed(sat_coord(quo_x, tag_x_out.neg, tag_x_out.hit));
        m_data_next.hit_y = $signed(sat_coord(quo_y, tag_y_out.neg, tag_x_out.hit));
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tag_x_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    // A hit found in stage 4 has its wall parameter strictly between the ends.
    `ASSERT_IMPLIES(a_t_inside, aclk, aresetn,
        vld_reg[3] && hit4_reg, (tn4_reg != '0) && (tn4_reg < dn4_reg))

    // A hit moving on from stage 4 yields a nonzero weight for the start point.
    `ASSERT_NEXT(a_weight_nonzero, aclk, aresetn,
        adv && vld_reg[3] && hit4_reg, vld_reg[4] && hit5_reg && (w5_reg != '0))

    // The two dividers carry the same transaction at the same time.
    `ASSERT_IMPLIES(a_div_lockstep, aclk, aresetn,
        tag_x_out.valid, tag_y_out.valid && (tag_y_out.hit == tag_x_out.hit))

    // A miss always reports a zero crossing point.
    `ASSERT_IMPLIES(a_miss_zero, aclk, aresetn,
        m_valid_reg && !m_data_reg.hit, (m_data_reg.hit_x == '0) && (m_data_reg.hit_y == '0))

endmodule
